@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the engine start controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock edge, disabled while in reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, disabled while in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/resc_pkg.sv @@
// ----------------------------------------------------------------------------
// resc_pkg
// Types and constants of the remote engine start controller.
// ----------------------------------------------------------------------------
package resc_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_LED   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        RPL_ACK      = 3'd0,
        RPL_STARTING = 3'd1,
        RPL_ALREADY  = 3'd2,
        RPL_STOPPED  = 3'd3,
        RPL_VOLTAGE  = 3'd4,
        RPL_BUSY     = 3'd5
    } reply_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STARTED   = 3'd1,
        EV_FAILED    = 3'd2,
        EV_STOPPED   = 3'd3,
        EV_ALREADY   = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_WARM  = 2'd1,
        PH_CRANK = 2'd2,
        PH_RUN   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_IGN_DELAY  = 2'd0,
        REG_CRANK_TO   = 2'd1,
        REG_CRANK_STOP = 2'd2,
        REG_ALREADY    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        reply_t      reply_code;
        logic [7:0]  reply_value;
        event_t      event_res;
        logic        ignition_on;
        logic        starter_on;
        logic        led_on;
        phase_t      phase_now;
    } result_t;

    localparam logic [15:0] IGN_DELAY_RST  = 16'd3000;
    localparam logic [15:0] CRANK_TO_RST   = 16'd2000;
    localparam logic [15:0] CRANK_STOP_RST = 16'd12500;
    localparam logic [15:0] ALREADY_RST    = 16'd13000;

    localparam logic [10:0] MS_PER_SEC_LIM  = 11'd1000;
    localparam logic [6:0]  SEC_PER_MIN_LIM = 7'd60;
    localparam logic [7:0]  ARG_KEEP        = 8'd255;

    // mv / 100 = (mv * 5243) >> 19, exact for mv below 43690
    localparam logic [15:0] MV_SAT_LIMIT = 16'd25600;
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

endpackage

@@ design/remote_engine_start_controller_top.sv @@
// ----------------------------------------------------------------------------
// remote_engine_start_controller_top
// Remote engine start sequencer: ignition warmup, cranking, timed run.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one word per 1 ms tick or command (start, stop,
//   voltage query, led set), each with the current battery sample in mV.
//   Result channel (m_*): exactly one result word per input word, showing
//   the reply, an event code and the relay/led/phase state after the word.
//   Config port: cfg_wr_en/cfg_index/cfg_wdata write the four 16-bit
//   thresholds; write only while no words are in flight.
//   Result path: a taken word's result is registered into the result
//   register on m_* when it is free; a stalled word waits in the skid.
//   Throughput: one word per cycle while s_ready is high; the state update
//   is a single combinational pass from the state registers to the buffer.
//   Stalls: a two-entry output buffer (result register plus skid) keeps
//   s_ready high while one result waits; s_ready is low whenever the skid
//   entry is occupied, and comes back the cycle after m_ready drains it.
//   Reset (aresetn low, synchronous): phase stopped, relays off, led on,
//   counters zero, thresholds back to defaults, output buffer empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module remote_engine_start_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_arg_byte,
    input  logic [15:0] s_battery_mv,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_reply_code,
    output logic [7:0]  m_reply_value,
    output logic [2:0]  m_event_res,
    output logic        m_ignition_on,
    output logic        m_starter_on,
    output logic        m_led_on,
    output logic [1:0]  m_phase_now
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] ign_delay_reg;
    logic [15:0] crank_to_reg;
    logic [15:0] crank_stop_reg;
    logic [15:0] already_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ign_delay_reg  <= resc_pkg::IGN_DELAY_RST;
            crank_to_reg   <= resc_pkg::CRANK_TO_RST;
            crank_stop_reg <= resc_pkg::CRANK_STOP_RST;
            already_reg    <= resc_pkg::ALREADY_RST;
        end else if (cfg_wr_en) begin
            case (resc_pkg::reg_idx_t'(cfg_index))
                resc_pkg::REG_IGN_DELAY:  ign_delay_reg  <= cfg_wdata;
                resc_pkg::REG_CRANK_TO:   crank_to_reg   <= cfg_wdata;
                resc_pkg::REG_CRANK_STOP: crank_stop_reg <= cfg_wdata;
                resc_pkg::REG_ALREADY:    already_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    resc_pkg::phase_t phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  minutes_reg, minutes_next;
    logic [10:0] ms_reg, ms_next;
    logic [6:0]  sec_reg, sec_next;
    logic        timed_reg, timed_next;
    logic        ign_reg, ign_next;
    logic        led_reg, led_next;

    resc_pkg::result_t res_next;

    // output buffer
    resc_pkg::result_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    logic push, pop;
    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    // Voltage query: saturate at 25.5 V, else reciprocal multiply by 1/100.
    logic [28:0] div_prod;
    logic [7:0]  volt_q;
    assign div_prod = s_battery_mv * resc_pkg::DIV100_RECIP;
    assign volt_q   = (s_battery_mv >= resc_pkg::MV_SAT_LIMIT) ? 8'hFF
                    : div_prod[resc_pkg::DIV100_SHIFT +: 8];

    // Saturating phase timer increment
    logic [15:0] timer_inc;
    assign timer_inc = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;

    // Run countdown helpers
    logic [10:0] ms_inc;
    logic        sec_roll;
    logic [6:0]  sec_inc;
    assign ms_inc   = ms_reg + 11'd1;
    assign sec_roll = ms_inc > resc_pkg::MS_PER_SEC_LIM;
    assign sec_inc  = sec_reg + {6'd0, sec_roll};

    logic busy;
    assign busy = (phase_reg == resc_pkg::PH_WARM) || (phase_reg == resc_pkg::PH_CRANK);

    always_comb begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        minutes_next = minutes_reg;
        ms_next      = ms_reg;
        sec_next     = sec_reg;
        timed_next   = timed_reg;
        ign_next     = ign_reg;
        led_next     = led_reg;
        res_next.reply_code  = resc_pkg::RPL_ACK;
        res_next.reply_value = 8'd0;
        res_next.event_res   = resc_pkg::EV_NONE;

        if (s_cmd == resc_pkg::CMD_TICK) begin
            case (phase_reg)
                resc_pkg::PH_WARM: begin
                    if (timer_inc >= ign_delay_reg) begin
                        phase_next = resc_pkg::PH_CRANK;
                        timer_next = 16'd0;
                    end else begin
                        timer_next = timer_inc;
                    end
                end
                resc_pkg::PH_CRANK: begin
                    if (s_battery_mv >= crank_stop_reg) begin
                        phase_next = resc_pkg::PH_RUN;
                        res_next.event_res = resc_pkg::EV_STARTED;
                    end else if (timer_reg > crank_to_reg) begin
                        ign_next   = 1'b0;
                        phase_next = resc_pkg::PH_STOP;
                        timed_next = 1'b0;
                        res_next.event_res = resc_pkg::EV_FAILED;
                    end else begin
                        timer_next = timer_inc;
                    end
                end
                resc_pkg::PH_RUN: begin
                    if (timed_reg) begin
                        if (minutes_reg != 8'd0) begin
                            // strict compares: rollover at 1001 ms and 61 s
                            ms_next = sec_roll ? 11'd0 : ms_inc;
                            if (sec_inc > resc_pkg::SEC_PER_MIN_LIM) begin
                                sec_next     = 7'd0;
                                minutes_next = minutes_reg - 8'd1;
                            end else begin
                                sec_next = sec_inc;
                            end
                        end else begin
                            ign_next   = 1'b0;
                            phase_next = resc_pkg::PH_STOP;
                            timed_next = 1'b0;
                            res_next.event_res = resc_pkg::EV_STOPPED;
                        end
                    end
                end
                default: ;
            endcase
        end else if (busy && (s_cmd <= resc_pkg::CMD_LED)) begin
            res_next.reply_code = resc_pkg::RPL_BUSY;
        end else begin
            case (s_cmd)
                resc_pkg::CMD_START: begin
                    if (s_battery_mv > already_reg) begin
                        phase_next = resc_pkg::PH_RUN;
                        res_next.reply_code = resc_pkg::RPL_ALREADY;
                        res_next.event_res  = resc_pkg::EV_ALREADY;
                    end else begin
                        if (s_arg_byte != resc_pkg::ARG_KEEP) begin
                            minutes_next = s_arg_byte;
                        end
                        timed_next = 1'b1;
                        ign_next   = 1'b1;
                        phase_next = resc_pkg::PH_WARM;
                        timer_next = 16'd0;
                        res_next.reply_code = resc_pkg::RPL_STARTING;
                    end
                end
                resc_pkg::CMD_STOP: begin
                    ign_next   = 1'b0;
                    phase_next = resc_pkg::PH_STOP;
                    timed_next = 1'b0;
                    res_next.reply_code = resc_pkg::RPL_STOPPED;
                    res_next.event_res  = resc_pkg::EV_STOPPED;
                end
                resc_pkg::CMD_QUERY: begin
                    res_next.reply_code  = resc_pkg::RPL_VOLTAGE;
                    res_next.reply_value = volt_q;
                end
                resc_pkg::CMD_LED: begin
                    if (s_arg_byte != resc_pkg::ARG_KEEP) begin
                        led_next = (s_arg_byte != 8'd0);
                    end
                end
                default: ;  // unknown codes: plain ack, no change
            endcase
        end

        res_next.ignition_on = ign_next;
        res_next.starter_on  = (phase_next == resc_pkg::PH_CRANK);
        res_next.led_on      = led_next;
        res_next.phase_now   = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= resc_pkg::PH_STOP;
            timer_reg   <= 16'd0;
            minutes_reg <= 8'd0;
            ms_reg      <= 11'd0;
            sec_reg     <= 7'd0;
            timed_reg   <= 1'b0;
            ign_reg     <= 1'b0;
            led_reg     <= 1'b1;
        end else if (push) begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            minutes_reg <= minutes_next;
            ms_reg      <= ms_next;
            sec_reg     <= sec_next;
            timed_reg   <= timed_next;
            ign_reg     <= ign_next;
            led_reg     <= led_next;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: result register plus one skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= res_next;
            end else begin
                out_reg <= res_next;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_reply_code  = out_reg.reply_code;
    assign m_reply_value = out_reg.reply_value;
    assign m_event_res   = out_reg.event_res;
    assign m_ignition_on = out_reg.ignition_on;
    assign m_starter_on  = out_reg.starter_on;
    assign m_led_on      = out_reg.led_on;
    assign m_phase_now   = out_reg.phase_now;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid full, result empty")
    `ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, push && out_valid_reg && !m_ready, skid_valid_reg, "stalled word not held in skid")
    `ASSERT_IMPL(a_busy_has_ign, aclk, aresetn, busy, ign_reg, "warmup or crank without ignition")
    `ASSERT_IMPL(a_starter_with_ign, aclk, aresetn, m_valid && m_starter_on, m_ignition_on, "starter driven without ignition")

endmodule
